// File: rtl/core/vvfe_pkg.sv
// Shared types and constants for the voxel visible-face extractor.
// Used by vvfe_front, vvfe_queue, vvfe_back and the top level; no dependencies.
package vvfe_pkg;

   localparam int CHUNK_SIDE_DEF = 16;
   localparam int CHUNK_TALL_DEF = 256;

   localparam int X_W     = 4;
   localparam int Y_W     = 8;
   localparam int Z_W     = 4;
   localparam int SIDE_W  = 2;
   localparam int DIR_W   = 3;
   localparam int NP_W    = 4;
   localparam int COUNT_W = 19;
   localparam int BASE_W  = 21;

   localparam int DIR_COUNT   = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_WRITE_BLOCK  = 2'd0,
      OP_WRITE_BORDER = 2'd1,
      OP_MESH         = 2'd2,
      OP_NEW_MESH     = 2'd3
   } op_type;

   // Border slab codes, also the bit positions in the neighbor-present register
   localparam logic [SIDE_W-1:0] SIDE_NEG_X = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_POS_X = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_NEG_Z = 2'd2;
   localparam logic [SIDE_W-1:0] SIDE_POS_Z = 2'd3;

   // Face directions, also the bit positions in the visibility mask
   localparam logic [DIR_W-1:0] DIR_POS_X = 3'd0;
   localparam logic [DIR_W-1:0] DIR_NEG_X = 3'd1;
   localparam logic [DIR_W-1:0] DIR_POS_Y = 3'd2;
   localparam logic [DIR_W-1:0] DIR_NEG_Y = 3'd3;
   localparam logic [DIR_W-1:0] DIR_POS_Z = 3'd4;
   localparam logic [DIR_W-1:0] DIR_NEG_Z = 3'd5;

   typedef struct packed {
      logic x_lo;
      logic x_hi;
      logic y_lo;
      logic y_hi;
      logic z_lo;
      logic z_hi;
   } bound_type;

   typedef struct packed {
      op_type            op;
      logic [X_W-1:0]    x;
      logic [Y_W-1:0]    y;
      logic [Z_W-1:0]    z;
      logic [SIDE_W-1:0] side;
      logic              solid;
      bound_type         bound;
   } cmd_type;

endpackage

// File: rtl/core/voxel_visible_face_extractor.sv
// Top level of the voxel visible-face extractor: front end, command queue
// and back end. Depends on vvfe_pkg, vvfe_front, vvfe_queue and vvfe_back.
//
// Usage:
//   req_* carries one transaction per accepted item (valid high, stall low):
//   block writes, border slab writes, mesh requests and mesh restarts.
//   rsp_* returns one record per visible face of a meshed solid block, in
//   the order +x, -x, +y, -y, +z, -z, with rsp_last on the block's final face.
//   csr_wr_en/csr_wr_data load the 4-bit neighbor-present mask; write it only
//   while the block is idle.
// Sequencing:
//   A write or restart is handled by the back end as it is popped. A mesh request
//   is popped, probed (two block-store reads and one border read per cycle) and
//   evaluated, then each of its visible faces is emitted in turn.
//   A 4-entry queue lets requests be accepted while the back end works;
//   req_stall rises only when that queue is full.
// Reset clears the queue, face count, mask register and result valid. The
//   stores are not cleared. A stalled result holds rsp_* until taken; the back
//   end waits before its next face meanwhile, and the queue keeps taking
//   requests until it fills.
module voxel_visible_face_extractor import vvfe_pkg::*; #(
   parameter int CHUNK_SIDE = CHUNK_SIDE_DEF,
   parameter int CHUNK_TALL = CHUNK_TALL_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [X_W-1:0]     req_x,
   input  logic [Y_W-1:0]     req_y,
   input  logic [Z_W-1:0]     req_z,
   input  logic [SIDE_W-1:0]  req_side,
   input  logic               req_solid,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [X_W-1:0]     rsp_face_x,
   output logic [Y_W-1:0]     rsp_face_y,
   output logic [Z_W-1:0]     rsp_face_z,
   output logic [DIR_W-1:0]   rsp_direction,
   output logic [BASE_W-1:0]  rsp_base_vertex,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [NP_W-1:0]    csr_wr_data
);

   logic    q_full;
   logic    q_push;
   cmd_type q_push_item;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_item;

   vvfe_front #(
      .CHUNK_SIDE (CHUNK_SIDE),
      .CHUNK_TALL (CHUNK_TALL)
   ) u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_x         (req_x),
      .req_y         (req_y),
      .req_z         (req_z),
      .req_side      (req_side),
      .req_solid     (req_solid),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (q_push_item)
   );

   vvfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_item)
   );

   vvfe_back #(
      .CHUNK_SIDE (CHUNK_SIDE),
      .CHUNK_TALL (CHUNK_TALL)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_face_x      (rsp_face_x),
      .rsp_face_y      (rsp_face_y),
      .rsp_face_z      (rsp_face_z),
      .rsp_direction   (rsp_direction),
      .rsp_base_vertex (rsp_base_vertex),
      .rsp_last        (rsp_last)
   );

endmodule

// File: rtl/core/vvfe_front.sv
// Front end: accepts request transactions, drops those that do nothing and
// tags the rest with chunk-boundary flags. Depends on vvfe_pkg.
module vvfe_front import vvfe_pkg::*; #(
   parameter int CHUNK_SIDE = CHUNK_SIDE_DEF,
   parameter int CHUNK_TALL = CHUNK_TALL_DEF
) (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_operation,
   input  logic [X_W-1:0]    req_x,
   input  logic [Y_W-1:0]    req_y,
   input  logic [Z_W-1:0]    req_z,
   input  logic [SIDE_W-1:0] req_side,
   input  logic              req_solid,
   input  logic              q_full,
   output logic              q_push,
   output cmd_type           q_item
);

   op_type op;
   logic   x_ok;
   logic   y_ok;
   logic   z_ok;
   logic   keep;

   assign op   = op_type'(req_operation);
   assign x_ok = 32'(req_x) < CHUNK_SIDE;
   assign y_ok = 32'(req_y) < CHUNK_TALL;
   assign z_ok = 32'(req_z) < CHUNK_SIDE;

   // Out-of-range writes and meshes have no effect: drop them here
   always_comb begin
      unique case (op)
         OP_NEW_MESH:     keep = 1'b1;
         OP_WRITE_BORDER: keep = x_ok && y_ok;
         OP_WRITE_BLOCK,
         OP_MESH:         keep = x_ok && y_ok && z_ok;
      endcase
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full && keep;

   always_comb begin
      q_item.op         = op;
      q_item.x          = req_x;
      q_item.y          = req_y;
      q_item.z          = req_z;
      q_item.side       = req_side;
      q_item.solid      = req_solid;
      q_item.bound.x_lo = req_x == '0;
      q_item.bound.x_hi = 32'(req_x) == CHUNK_SIDE - 1;
      q_item.bound.y_lo = req_y == '0;
      q_item.bound.y_hi = 32'(req_y) == CHUNK_TALL - 1;
      q_item.bound.z_lo = req_z == '0;
      q_item.bound.z_hi = 32'(req_z) == CHUNK_SIDE - 1;
   end

endmodule

// File: rtl/core/vvfe_queue.sv
// Short command queue between the front end and the back end.
// Depends on vvfe_pkg for the command type and depth.
module vvfe_queue import vvfe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_item,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_item
);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               do_pop;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= QPTR_W'((32'(wr_ptr_ff) + 1) % QUEUE_DEPTH);
         end
         if (do_pop) begin
            rd_ptr_ff <= QPTR_W'((32'(rd_ptr_ff) + 1) % QUEUE_DEPTH);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: rtl/core/vvfe_back.sv
// Back end: block and border stores, neighbor probe sequencer, face emitter
// with result register and running face count. Depends on vvfe_pkg.
module vvfe_back import vvfe_pkg::*; #(
   parameter int CHUNK_SIDE = CHUNK_SIDE_DEF,
   parameter int CHUNK_TALL = CHUNK_TALL_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  cmd_type            q_item,
   output logic               q_pop,
   input  logic               csr_wr_en,
   input  logic [NP_W-1:0]    csr_wr_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [X_W-1:0]     rsp_face_x,
   output logic [Y_W-1:0]     rsp_face_y,
   output logic [Z_W-1:0]     rsp_face_z,
   output logic [DIR_W-1:0]   rsp_direction,
   output logic [BASE_W-1:0]  rsp_base_vertex,
   output logic               rsp_last
);

   localparam int SW = ($clog2(CHUNK_SIDE) < X_W) ? $clog2(CHUNK_SIDE) : X_W;
   localparam int TW = ($clog2(CHUNK_TALL) < Y_W) ? $clog2(CHUNK_TALL) : Y_W;
   localparam int BLOCK_AW  = 2 * SW + TW;
   localparam int BORDER_AW = SIDE_W + TW + SW;

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EMIT} state_type;

   logic block_mem_ff  [2**BLOCK_AW];
   logic border_mem_ff [2**BORDER_AW];

   state_type            state_ff;
   logic [2:0]           phase_ff;
   cmd_type              cur_ff;
   logic                 self_ff;
   logic [DIR_COUNT-1:0] air_ff;
   logic [DIR_COUNT-1:0] mask_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [NP_W-1:0]      np_ff;
   logic                 rd_a_ff;
   logic                 rd_b_ff;
   logic                 rd_s_ff;

   logic                 rsp_valid_ff;
   logic [X_W-1:0]       face_x_ff;
   logic [Y_W-1:0]       face_y_ff;
   logic [Z_W-1:0]       face_z_ff;
   logic [DIR_W-1:0]     direction_ff;
   logic [BASE_W-1:0]    base_ff;
   logic                 last_ff;

   logic [SW-1:0]        cx, cx_p, cx_m, cz, cz_p, cz_m;
   logic [TW-1:0]        cy, cy_p, cy_m;
   logic [BLOCK_AW-1:0]  addr_a, addr_b, self_addr;
   logic [BORDER_AW-1:0] addr_s, xside_addr, zside_addr;
   logic [SIDE_W-1:0]    xside, zside;
   logic                 wr_block, wr_border;
   logic                 air_neg_z;
   logic [DIR_COUNT-1:0] mask_full;
   logic [DIR_W-1:0]     dir_sel;
   logic [DIR_COUNT-1:0] mask_rest;
   logic                 load;

   assign cx   = cur_ff.x[SW-1:0];
   assign cz   = cur_ff.z[SW-1:0];
   assign cy   = cur_ff.y[TW-1:0];
   assign cx_p = cx + 1'b1;
   assign cx_m = cx - 1'b1;
   assign cz_p = cz + 1'b1;
   assign cz_m = cz - 1'b1;
   assign cy_p = cy + 1'b1;
   assign cy_m = cy - 1'b1;

   assign xside      = cur_ff.bound.x_lo ? SIDE_NEG_X : SIDE_POS_X;
   assign zside      = cur_ff.bound.z_lo ? SIDE_NEG_Z : SIDE_POS_Z;
   assign self_addr  = {cx, cy, cz};
   assign xside_addr = {xside, cy, cz};
   assign zside_addr = {zside, cy, cx};

   // Two block reads and one border read per cycle; the read data is registered
   always_comb begin
      unique case (phase_ff)
         3'd0: begin
            addr_a = self_addr;
            addr_b = {cx_p, cy, cz};
            addr_s = xside_addr;
         end
         3'd1: begin
            addr_a = {cx_m, cy, cz};
            addr_b = {cx, cy_p, cz};
            addr_s = xside_addr;
         end
         3'd2: begin
            addr_a = {cx, cy_m, cz};
            addr_b = {cx, cy, cz_p};
            addr_s = zside_addr;
         end
         default: begin
            addr_a = {cx, cy, cz_m};
            addr_b = self_addr;
            addr_s = zside_addr;
         end
      endcase
   end

   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign wr_block  = q_pop && (q_item.op == OP_WRITE_BLOCK);
   assign wr_border = q_pop && (q_item.op == OP_WRITE_BORDER);

   always_ff @(posedge clock) begin
      if (wr_block) begin
         block_mem_ff[{q_item.x[SW-1:0], q_item.y[TW-1:0], q_item.z[SW-1:0]}]
            <= q_item.solid;
      end
      if (wr_border) begin
         border_mem_ff[{q_item.side, q_item.y[TW-1:0], q_item.x[SW-1:0]}] <= q_item.solid;
      end
      rd_a_ff <= block_mem_ff[addr_a];
      rd_b_ff <= block_mem_ff[addr_b];
      rd_s_ff <= border_mem_ff[addr_s];
   end

   assign air_neg_z = cur_ff.bound.z_lo ? (np_ff[SIDE_NEG_Z] && !rd_s_ff) : !rd_a_ff;
   assign mask_full = {air_neg_z, air_ff[DIR_COUNT-2:0]};

   // Lowest pending direction goes out first
   always_comb begin
      dir_sel = '0;
      for (int i = DIR_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            dir_sel = DIR_W'(i);
         end
      end
   end

   assign mask_rest = mask_ff & ~(DIR_COUNT'(1) << dir_sel);
   assign load      = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         count_ff     <= '0;
         np_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            np_ff <= csr_wr_data;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  unique case (q_item.op)
                     OP_NEW_MESH: count_ff <= '0;
                     OP_MESH: begin
                        cur_ff   <= q_item;
                        phase_ff <= '0;
                        state_ff <= ST_READ;
                     end
                     OP_WRITE_BLOCK,
                     OP_WRITE_BORDER: ;
                  endcase
               end
            end
            ST_READ: begin
               phase_ff <= phase_ff + 1'b1;
               unique case (phase_ff)
                  3'd1: begin
                     self_ff <= rd_a_ff;
                     air_ff[DIR_POS_X] <= cur_ff.bound.x_hi ?
                        (np_ff[SIDE_POS_X] && !rd_s_ff) : !rd_b_ff;
                  end
                  3'd2: begin
                     air_ff[DIR_NEG_X] <= cur_ff.bound.x_lo ?
                        (np_ff[SIDE_NEG_X] && !rd_s_ff) : !rd_a_ff;
                     air_ff[DIR_POS_Y] <= cur_ff.bound.y_hi || !rd_b_ff;
                  end
                  3'd3: begin
                     air_ff[DIR_NEG_Y] <= !cur_ff.bound.y_lo && !rd_a_ff;
                     air_ff[DIR_POS_Z] <= cur_ff.bound.z_hi ?
                        (np_ff[SIDE_POS_Z] && !rd_s_ff) : !rd_b_ff;
                  end
                  3'd4: begin
                     air_ff[DIR_NEG_Z] <= air_neg_z;
                     mask_ff           <= mask_full;
                     if (self_ff && (mask_full != '0)) begin
                        state_ff <= ST_EMIT;
                     end else begin
                        state_ff <= ST_IDLE;
                     end
                  end
                  default: ;
               endcase
            end
            ST_EMIT: begin
               if (load) begin
                  face_x_ff    <= cur_ff.x;
                  face_y_ff    <= cur_ff.y;
                  face_z_ff    <= cur_ff.z;
                  direction_ff <= dir_sel;
                  base_ff      <= {count_ff, 2'b00};
                  last_ff      <= mask_rest == '0;
                  count_ff     <= count_ff + 1'b1;
                  mask_ff      <= mask_rest;
                  if (mask_rest == '0) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_face_x      = face_x_ff;
   assign rsp_face_y      = face_y_ff;
   assign rsp_face_z      = face_z_ff;
   assign rsp_direction   = direction_ff;
   assign rsp_base_vertex = base_ff;
   assign rsp_last        = last_ff;

   a_emit_has_faces: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> mask_ff != '0)
      else $error("emit state with empty face mask");

   a_last_ends_block: assert property (@(posedge clock) disable iff (reset)
      load && (mask_rest == '0) |=> state_ff == ST_IDLE && rsp_last && rsp_valid)
      else $error("last face did not end the block");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      load |=> count_ff == COUNT_W'($past(count_ff) + 1'b1))
      else $error("face count did not advance by one");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> phase_ff <= 3'd4)
      else $error("probe phase out of range");

endmodule
